FILE: design/lstm_pkg.sv
`default_nettype none
package lstm_pkg;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam int ACC_W = 40;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        gate_sel;
        logic [3:0]        position;
        logic signed [15:0] value;
        logic              last;
    } t_item;

    function automatic logic [12:0] sig_entry(input logic [5:0] k);
        logic [12:0] v;
        case (k)
            6'd0: v = 13'd2048;  6'd1: v = 13'd2303;  6'd2: v = 13'd2550;
            6'd3: v = 13'd2782;  6'd4: v = 13'd2994;  6'd5: v = 13'd3184;
            6'd6: v = 13'd3349;  6'd7: v = 13'd3490;  6'd8: v = 13'd3608;
            6'd9: v = 13'd3705;  6'd10: v = 13'd3785; 6'd11: v = 13'd3850;
            6'd12: v = 13'd3902; 6'd13: v = 13'd3943; 6'd14: v = 13'd3976;
            6'd15: v = 13'd4002; 6'd16: v = 13'd4022; 6'd17: v = 13'd4038;
            6'd18: v = 13'd4051; 6'd19: v = 13'd4061; 6'd20: v = 13'd4069;
            6'd21: v = 13'd4075; 6'd22: v = 13'd4079; 6'd23: v = 13'd4083;
            6'd24: v = 13'd4086; 6'd25: v = 13'd4088; 6'd26: v = 13'd4090;
            6'd27: v = 13'd4091; 6'd28: v = 13'd4092; 6'd29: v = 13'd4093;
            6'd30: v = 13'd4094; 6'd31: v = 13'd4094;
            default: v = 13'd4095;
        endcase
        return v;
    endfunction

    function automatic logic [12:0] tanh_entry(input logic [5:0] k);
        logic [12:0] v;
        case (k)
            6'd0: v = 13'd0;     6'd1: v = 13'd1003;  6'd2: v = 13'd1893;
            6'd3: v = 13'd2602;  6'd4: v = 13'd3119;  6'd5: v = 13'd3475;
            6'd6: v = 13'd3707;  6'd7: v = 13'd3856;  6'd8: v = 13'd3949;
            6'd9: v = 13'd4006;  6'd10: v = 13'd4041; 6'd11: v = 13'd4063;
            6'd12: v = 13'd4076; 6'd13: v = 13'd4084; 6'd14: v = 13'd4089;
            6'd15: v = 13'd4091; 6'd16: v = 13'd4093; 6'd17: v = 13'd4094;
            6'd18: v = 13'd4095; 6'd19: v = 13'd4095;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

    // Piecewise linear lookup on |x|; tanh when is_tanh, else sigmoid.
    function automatic logic signed [15:0] act(input logic signed [15:0] x,
                                              input logic is_tanh);
        logic [16:0]        mag;
        logic [5:0]         idx;
        logic [9:0]         frac;
        logic signed [13:0] a;
        logic signed [13:0] b;
        logic signed [25:0] d;
        logic signed [13:0] y;
        logic signed [15:0] r;
        mag  = (x < 0) ? 17'(-$signed({x[15], x})) : 17'(x);
        idx  = 6'(mag >> 10);
        frac = mag[9:0];
        a = is_tanh ? $signed({1'b0, tanh_entry(idx)}) : $signed({1'b0, sig_entry(idx)});
        b = is_tanh ? $signed({1'b0, tanh_entry(6'(idx + 6'd1))})
                    : $signed({1'b0, sig_entry(6'(idx + 6'd1))});
        d = (26'(b - a) * $signed({16'd0, frac}) + 26'sd512) >>> 10;
        if (idx >= 6'd32) begin
            y = a;
        end else begin
            y = 14'(a + 14'(d));
        end
        if (x < 0) begin
            r = is_tanh ? 16'(-y) : 16'(14'sd4096 - y);
        end else begin
            r = 16'(y);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = (v + ACC_W'(2048)) >>> 12;
        if (q > 32767) return 16'sh7fff;
        if (q < -32768) return 16'sh8000;
        return q[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/lstm_front.sv
`default_nettype none
module lstm_front #(
    parameter int DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire lstm_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire                  i_take,
    output lstm_pkg::t_item      o_item
);
    localparam int AW = $clog2(DEPTH);

    lstm_pkg::t_item  r_q [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : AW'(r_wp + 1'b1);
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : AW'(r_rp + 1'b1);
            r_cnt <= (AW+1)'(r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop));
        end
    end
endmodule
`default_nettype wire

FILE: design/lstm_back.sv
`default_nettype none
module lstm_back #(
    parameter int NUM_IN = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_take,
    input  wire lstm_pkg::t_item  i_item,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic signed [15:0]    o_hidden_out,
    output logic signed [15:0]    o_cell_out
);
    localparam int ROW = NUM_IN + 2;
    localparam int RAW = $clog2(ROW);
    localparam int W = lstm_pkg::ACC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MAC  = 4'd2;
    localparam logic [3:0] S_A0   = 4'd3;
    localparam logic [3:0] S_A1   = 4'd4;
    localparam logic [3:0] S_A2   = 4'd5;
    localparam logic [3:0] S_A3   = 4'd6;
    localparam logic [3:0] S_C0   = 4'd7;
    localparam logic [3:0] S_C1   = 4'd8;
    localparam logic [3:0] S_C2   = 4'd9;
    localparam logic [3:0] S_H0   = 4'd10;
    localparam logic [3:0] S_H1   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [63:0]            r_mem [ROW];
    logic [3:0]             r_state;
    lstm_pkg::t_item        r_it;
    logic                   r_open;
    logic signed [W-1:0]    r_acc [4];
    logic signed [15:0]     r_w [4];
    logic signed [15:0]     r_bias [4];
    logic signed [15:0]     r_rec [4];
    logic signed [15:0]     r_g [4];
    logic signed [15:0]     r_cell, r_prev;
    logic signed [31:0]     r_p0, r_p1;
    logic                   w_inpos, w_loadok;
    logic [RAW-1:0]         w_rd_row;

    assign o_take  = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_hidden_out = r_prev;
    assign o_cell_out   = r_cell;
    assign w_inpos  = (i_item.position >= 4'd1) && (32'(i_item.position) <= NUM_IN);
    assign w_loadok = (32'(i_item.position) <= NUM_IN + 1);
    assign w_rd_row = w_inpos ? RAW'(i_item.position) : RAW'(0);

    // Weight table: one row per position with one 16-bit lane per gate.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_take && i_item.req_type == lstm_pkg::REQ_LOAD && w_loadok) begin
            r_mem[RAW'(i_item.position)][16*i_item.gate_sel +: 16] <= i_item.value;
        end
        if (r_state == S_IDLE) begin
            for (int g = 0; g < 4; g++) begin
                r_w[g] <= $signed(r_mem[w_rd_row][16*g +: 16]);
            end
        end
        if (r_state == S_RD) begin
            for (int g = 0; g < 4; g++) begin
                r_bias[g] <= $signed(r_mem[RAW'(ROW-1)][16*g +: 16]);
                r_rec[g]  <= $signed(r_mem[RAW'(0)][16*g +: 16]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= 1'b0;
            r_cell  <= '0;
            r_prev  <= '0;
            for (int g = 0; g < 4; g++) r_acc[g] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_item.req_type == lstm_pkg::REQ_SAMPLE) begin
                        r_it    <= '{req_type: i_item.req_type, gate_sel: i_item.gate_sel,
                                     position: w_inpos ? i_item.position : 4'd0,
                                     value: i_item.value, last: i_item.last};
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_MAC;
                S_MAC: begin
                    for (int g = 0; g < 4; g++) begin
                        r_acc[g] <= W'((r_open ? r_acc[g]
                                       : (W'(r_bias[g]) <<< 12) + W'(r_rec[g] * r_prev))
                                     + ((r_it.position != 4'd0) ? W'(r_w[g] * r_it.value)
                                                                 : W'(0)));
                    end
                    r_open  <= !r_it.last;
                    r_state <= r_it.last ? S_A0 : S_IDLE;
                end
                S_A0: begin r_g[0] <= lstm_pkg::act(lstm_pkg::to_q12(r_acc[0]), 1'b0);
                    r_state <= S_A1; end
                S_A1: begin r_g[1] <= lstm_pkg::act(lstm_pkg::to_q12(r_acc[1]), 1'b0);
                    r_state <= S_A2; end
                S_A2: begin r_g[2] <= lstm_pkg::act(lstm_pkg::to_q12(r_acc[2]), 1'b1);
                    r_state <= S_A3; end
                S_A3: begin r_g[3] <= lstm_pkg::act(lstm_pkg::to_q12(r_acc[3]), 1'b0);
                    r_state <= S_C0; end
                S_C0: begin r_p0 <= r_g[2] * r_g[1]; r_p1 <= r_g[0] * r_cell;
                    r_state <= S_C1; end
                S_C1: begin r_cell <= lstm_pkg::to_q12(W'(r_p0) + W'(r_p1));
                    r_state <= S_C2; end
                S_C2: begin r_g[2] <= lstm_pkg::act(r_cell, 1'b1); r_state <= S_H0; end
                S_H0: begin r_p0 <= r_g[2] * r_g[3]; r_state <= S_H1; end
                S_H1: begin r_prev <= lstm_pkg::to_q12(W'(r_p0)); r_state <= S_OUT; end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/lstm_unit_forward_step_core.sv
`default_nettype none
// A load is written to the table as it leaves the queue; a sample passes the table read
// and MAC states. A closing sample adds activation and state update before its beat.
// The back end takes a new beat only when idle; it does not overlap samples.
// A 4-beat queue lets input beats enter while the back end works or its output stalls.
// Synchronous active-low reset clears queue, step state, cell state and output; the
// weight table is not cleared.
module lstm_unit_forward_step_core #(
    parameter int NUM_IN = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire                i_req_type,
    input  wire [1:0]          i_gate_sel,
    input  wire [3:0]          i_position,
    input  wire signed [15:0]  i_value,
    input  wire                i_last,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_hidden_out,
    output logic signed [15:0] o_cell_out
);
    lstm_pkg::t_item w_in, w_q;
    logic            w_qv, w_take;

    assign w_in = '{req_type: i_req_type, gate_sel: i_gate_sel, position: i_position,
                    value: i_value, last: i_last};

    lstm_front #(.DEPTH(4)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(w_in), .o_valid(w_qv), .i_take(w_take), .o_item(w_q)
    );

    lstm_back #(.NUM_IN(NUM_IN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_take(w_take),
        .i_item(w_q), .o_valid(o_valid), .i_stall(i_stall),
        .o_hidden_out(o_hidden_out), .o_cell_out(o_cell_out)
    );
endmodule
`default_nettype wire

FILE: design/lstm_checker.sv
`default_nettype none
module lstm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [15:0] o_hidden_out,
    input wire [15:0] o_cell_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hidden_out) && $stable(o_cell_out))
        else $error("result changed while stalled");
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result repeated");
    a_no_back_to_back_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_valid, 2))
        else $error("result too soon");
endmodule

bind lstm_unit_forward_step_core lstm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_hidden_out(o_hidden_out),
    .o_cell_out(o_cell_out)
);
`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;

    localparam int NUM_IN   = 8;
    localparam int ROW_LEN  = NUM_IN + 2;
    localparam int N_RAND   = 1200;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic signed [15:0] hidden;
        logic signed [15:0] cstate;
    } t_unit_out;

    typedef struct {
        lstm_pkg::t_item item;
        logic            known;
        t_unit_out       want;
    } t_row;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic dut_stall;
    logic out_valid;
    logic req_type;
    logic [1:0] gate_sel;
    logic [3:0] position;
    logic signed [15:0] value;
    logic last;
    logic signed [15:0] hidden_out;
    logic signed [15:0] cell_out;

    int idle_pct;
    int stall_pct;
    int errors;
    longint cycles = 0;

    logic signed [15:0] weights [4*ROW_LEN];
    logic signed [47:0] gate_sum [4];
    logic step_open;
    logic signed [15:0] cell_q;
    logic signed [15:0] hid_q;
    t_unit_out pending_outputs [$];
    logic pending_known [$];
    t_unit_out pending_typed [$];

    lstm_unit_forward_step_core #(.NUM_IN(NUM_IN)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(dut_stall),
        .i_req_type(req_type), .i_gate_sel(gate_sel), .i_position(position),
        .i_value(value), .i_last(last), .o_valid(out_valid), .i_stall(in_stall),
        .o_hidden_out(hidden_out), .o_cell_out(cell_out)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [15:0] round_sat(input logic signed [47:0] v);
        logic signed [47:0] q;
        q = (v + 48'sd2048) >>> 12;
        if (q > 48'sd32767) return 16'sh7fff;
        if (q < -48'sd32768) return 16'sh8000;
        return q[15:0];
    endfunction

    function automatic int curve(input int mag, input bit is_tanh);
        int sg [33] = '{2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608, 3705,
                        3785, 3850, 3902, 3943, 3976, 4002, 4022, 4038, 4051, 4061,
                        4069, 4075, 4079, 4083, 4086, 4088, 4090, 4091, 4092, 4093,
                        4094, 4094, 4095};
        int th [33] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006,
                        4041, 4063, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095,
                        4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                        4096, 4096, 4096};
        int k;
        int f;
        int a;
        int b;
        k = mag >> 10;
        f = mag & 1023;
        a = is_tanh ? th[k > 32 ? 32 : k] : sg[k > 32 ? 32 : k];
        if (k >= 32) return a;
        b = is_tanh ? th[k+1] : sg[k+1];
        return a + (((b - a) * f + 512) >>> 10);
    endfunction

    function automatic int activate(input logic signed [15:0] x, input bit is_tanh);
        int xi;
        xi = x;
        if (xi >= 0) return curve(xi, is_tanh);
        return is_tanh ? -curve(-xi, 1'b1) : 4096 - curve(-xi, 1'b0);
    endfunction

    function automatic bit lstm_advance(input lstm_pkg::t_item it, output t_unit_out res);
        int g;
        int fg;
        int ig;
        int cg;
        int og;
        logic signed [15:0] c;
        logic signed [15:0] h;
        res = '0;
        if (it.req_type == lstm_pkg::REQ_LOAD) begin
            if (it.position <= NUM_IN + 1) begin
                weights[it.gate_sel*ROW_LEN + it.position] = it.value;
            end
            return 1'b0;
        end
        if (!step_open) begin
            for (g = 0; g < 4; g++) begin
                gate_sum[g] = 48'(weights[g*ROW_LEN+NUM_IN+1]) * 48'sd4096
                            + 48'(weights[g*ROW_LEN]) * 48'(hid_q);
            end
            step_open = 1'b1;
        end
        if (it.position >= 1 && it.position <= NUM_IN) begin
            for (g = 0; g < 4; g++) begin
                gate_sum[g] += 48'(weights[g*ROW_LEN+it.position]) * 48'(it.value);
            end
        end
        if (!it.last) return 1'b0;
        fg = activate(round_sat(gate_sum[0]), 1'b0);
        ig = activate(round_sat(gate_sum[1]), 1'b0);
        cg = activate(round_sat(gate_sum[2]), 1'b1);
        og = activate(round_sat(gate_sum[3]), 1'b0);
        c = round_sat(48'(cg) * 48'(ig) + 48'(fg) * 48'(cell_q));
        h = round_sat(48'(activate(c, 1'b1)) * 48'(og));
        cell_q = c;
        hid_q = h;
        step_open = 1'b0;
        res.hidden = h;
        res.cstate = c;
        return 1'b1;
    endfunction

    task automatic send_beat(input lstm_pkg::t_item it, input logic known,
                             input t_unit_out want);
        t_unit_out res;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= it.req_type;
        gate_sel <= it.gate_sel;
        position <= it.position;
        value <= it.value;
        last <= it.last;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        if (lstm_advance(it, res)) begin
            pending_outputs = {pending_outputs, res};
            pending_known = {pending_known, known};
            pending_typed = {pending_typed, want};
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_outputs.size() > 0) @(posedge clk);
    endtask

    function automatic lstm_pkg::t_item mk(input logic rt, input int gs, input int ps,
                                           input int v, input logic lst);
        lstm_pkg::t_item it;
        it.req_type = rt;
        it.gate_sel = 2'(gs);
        it.position = 4'(ps);
        it.value = 16'(v);
        it.last = lst;
        return it;
    endfunction

    task automatic load_all(input bit tiny);
        int g;
        int p;
        int v;
        for (g = 0; g < 4; g++) begin
            for (p = 0; p <= NUM_IN + 1; p++) begin
                if (tiny) v = $signed(16'($urandom_range(0, 4095))) - 2048;
                else v = $signed(16'($urandom));
                send_beat(mk(lstm_pkg::REQ_LOAD, g, p, v, $urandom_range(1)), 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_stall <= 1'b0;
        end else begin
            in_stall <= ($urandom_range(99) < stall_pct);
            if (out_valid && !in_stall) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: unexpected beat hidden=%0d cell=%0d",
                             $time, hidden_out, cell_out);
                    errors++;
                end else begin
                    t_unit_out w;
                    w = pending_outputs.pop_front();
                    if (pending_known.pop_front() && pending_typed[0] != w) begin
                        $display("%0t: typed row disagrees: expected %h actual %h",
                                 $time, pending_typed[0], w);
                        errors++;
                    end
                    void'(pending_typed.pop_front());
                    if (hidden_out !== w.hidden) begin
                        $display("%0t: hidden expected %0d actual %0d",
                                 $time, w.hidden, hidden_out);
                        errors++;
                    end
                    if (cell_out !== w.cstate) begin
                        $display("%0t: cell expected %0d actual %0d",
                                 $time, w.cstate, cell_out);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL lstm_unit_forward_step_core");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_unit_out zero_out;
        int i;
        int n;
        int g;
        int ph;
        int pos;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        gate_sel = '0;
        position = '0;
        value = '0;
        last = 1'b0;
        step_open = 1'b0;
        cell_q = '0;
        hid_q = '0;
        zero_out = '0;
        for (i = 0; i < 4*ROW_LEN; i++) weights[i] = '0;
        for (i = 0; i < 4; i++) gate_sum[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all-zero weights every gate sits at sigmoid(0)/tanh(0), so the first step's cell and output are zero.
        for (g = 0; g < 4; g++) begin
            for (i = 0; i <= NUM_IN + 1; i++) begin
                rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, g, i, 0, 1'b1), 1'b0, zero_out}};
            end
        end
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 3, 15, 16'h7fff, 1'b0), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 2, 0, 0, 1'b1), 1'b1, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 1, NUM_IN + 1, 16'h7fff, 1'b0),
                             1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 2, NUM_IN + 1, 16'h7fff, 1'b0),
                             1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 3, NUM_IN + 1, 16'h7fff, 1'b0),
                             1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 0, 1, 16'h8000, 1'b0), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 0, 1, 16'h7fff, 1'b0), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 0, NUM_IN, 16'h8000, 1'b0),
                             1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 3, 15, 16'h1234, 1'b1), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 0, 9, 16'h8000, 1'b0), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_LOAD, 0, 0, 16'h7fff, 1'b0), 1'b0, zero_out}};
        rows = {rows, t_row'{mk(lstm_pkg::REQ_SAMPLE, 1, 1, 16'h0fff, 1'b1), 1'b0, zero_out}};
        for (i = 0; i < rows.size(); i++) send_beat(rows[i].item, rows[i].known, rows[i].want);
        drain();

        n = 0;
        for (ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 55 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 55 : (ph == 3) ? 28 : 0;
            load_all(ph[0]);
            while (n < (ph + 1) * N_RAND / 4) begin
                if ($urandom_range(9) == 0) begin
                    send_beat(mk($urandom_range(1), $urandom_range(3), $urandom_range(15),
                                 $urandom, $urandom_range(1)), 1'b0, '0);
                    n++;
                end else begin
                    int len;
                    len = $urandom_range(1, NUM_IN);
                    for (i = 0; i < len; i++) begin
                        if ($urandom_range(19) == 0) begin
                            send_beat(mk(lstm_pkg::REQ_LOAD, $urandom_range(3),
                                         $urandom_range(NUM_IN + 1),
                                         $signed(16'($urandom_range(0, 8191))) - 4096,
                                         1'b0), 1'b0, '0);
                            n++;
                        end
                        pos = $urandom_range(1, NUM_IN);
                        send_beat(mk(lstm_pkg::REQ_SAMPLE, $urandom_range(3), pos,
                                     ph[0] ? $urandom : $urandom_range(0, 16383) - 8192,
                                     i == len - 1), 1'b0, '0);
                        n++;
                    end
                end
            end
            // Let the unit go quiet before the next phase rewrites the weights.
            if (step_open) send_beat(mk(lstm_pkg::REQ_SAMPLE, 0, 0, 0, 1'b1), 1'b0, '0);
            drain();
        end

        stall_pct = 0;
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("PASS lstm_unit_forward_step_core");
        end else begin
            $display("FAIL lstm_unit_forward_step_core");
        end
        $finish;
    end
endmodule
